/* hw/rtl/pidl_pkg.sv */
// Shared types, codes and elaboration helpers for the positional insert/delete list.
// Used by pidl_cell, pidl_or_tree and positional_insert_delete_list_top.
// No dependencies.
package pidl_pkg;

  localparam int DATA_W    = 32;
  localparam int POS_W     = 7;
  localparam int CNT_OUT_W = 7;
  localparam int OP_W      = 2;
  localparam int ST_W      = 2;
  localparam int DEPTH_DEF = 64;

  // operation codes (code 3 is unused and acts as a no-op)
  localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
  localparam logic [OP_W-1:0] OP_DELETE = 2'd1;
  localparam logic [OP_W-1:0] OP_READ   = 2'd2;

  // status codes
  localparam logic [ST_W-1:0] ST_OK    = 2'd0;
  localparam logic [ST_W-1:0] ST_RANGE = 2'd1;
  localparam logic [ST_W-1:0] ST_FULL  = 2'd2;
  localparam logic [ST_W-1:0] ST_EMPTY = 2'd3;

  // per-cell control of the current cycle
  typedef struct packed {
    logic take_prev;  // shift up: copy lower neighbor
    logic take_next;  // shift down: copy upper neighbor
    logic load;       // write the inserted value
    logic sel;        // this cell is the read target
  } cell_ctl_t;

  // node count after n rounds of 8:1 reduction
  function automatic int tree_width(input int depth, input int n);
    int w;
    w = depth;
    for (int m = 0; m < n; m++) w = (w + 7) / 8;
    return w;
  endfunction

  // number of 8:1 register stages until one word is left (at least one)
  function automatic int tree_levels(input int depth);
    int w;
    int lev;
    w   = depth;
    lev = 0;
    do begin
      w   = (w + 7) / 8;
      lev = lev + 1;
    end while (w > 1);
    return lev;
  endfunction

  // first node index of stage l in the flattened node store
  function automatic int tree_offset(input int depth, input int l);
    int off;
    off = 0;
    for (int m = 0; m < l; m++) off = off + tree_width(depth, m + 1);
    return off;
  endfunction

endpackage

/* hw/rtl/pidl_cell.sv */
// One list cell: holds one entry, shifts with its neighbors, offers a masked read word.
// Depends on pidl_pkg (cell_ctl_t, DATA_W).
module pidl_cell (
  input  logic                        clk,
  input  pidl_pkg::cell_ctl_t         ctl,
  input  logic [pidl_pkg::DATA_W-1:0] value,
  input  logic [pidl_pkg::DATA_W-1:0] prev_data,
  input  logic [pidl_pkg::DATA_W-1:0] next_data,
  output logic [pidl_pkg::DATA_W-1:0] data,
  output logic [pidl_pkg::DATA_W-1:0] rd_word
);

  always_ff @(posedge clk) begin
    priority if (ctl.load) begin
      data <= value;
    end else if (ctl.take_prev) begin
      data <= prev_data;
    end else if (ctl.take_next) begin
      data <= next_data;
    end
  end

  // only the selected cell drives a nonzero word into the OR tree
  always_ff @(posedge clk) begin
    rd_word <= ctl.sel ? data : '0;
  end

endmodule

/* hw/rtl/pidl_or_tree.sv */
// Registered 8:1 OR reduction tree that collects the masked read words of all cells.
// Depends on pidl_pkg (DATA_W, tree_width, tree_levels, tree_offset).
module pidl_or_tree #(
  parameter int DEPTH = pidl_pkg::DEPTH_DEF
) (
  input  logic                        clk,
  input  logic [pidl_pkg::DATA_W-1:0] din [DEPTH],
  output logic [pidl_pkg::DATA_W-1:0] dout
);

  localparam int LEV   = pidl_pkg::tree_levels(DEPTH);
  localparam int TOTAL = pidl_pkg::tree_offset(DEPTH, LEV);

  logic [pidl_pkg::DATA_W-1:0] node [TOTAL];

  for (genvar l = 0; l < LEV; l++) begin : g_lvl
    localparam int SW   = pidl_pkg::tree_width(DEPTH, l);
    localparam int OW   = pidl_pkg::tree_width(DEPTH, l + 1);
    localparam int OFF  = pidl_pkg::tree_offset(DEPTH, l);
    localparam int SOFF = pidl_pkg::tree_offset(DEPTH, (l > 0) ? l - 1 : 0);
    for (genvar j = 0; j < OW; j++) begin : g_node
      logic [pidl_pkg::DATA_W-1:0] leg [8];
      for (genvar k = 0; k < 8; k++) begin : g_leg
        if (8 * j + k < SW) begin : g_on
          if (l == 0) begin : g_src_in
            assign leg[k] = din[8 * j + k];
          end else begin : g_src_node
            assign leg[k] = node[SOFF + 8 * j + k];
          end
        end else begin : g_off
          assign leg[k] = '0;
        end
      end
      always_ff @(posedge clk) begin
        node[OFF + j] <= leg[0] | leg[1] | leg[2] | leg[3]
                       | leg[4] | leg[5] | leg[6] | leg[7];
      end
    end
  end

  assign dout = node[TOTAL - 1];

endmodule

/* hw/rtl/positional_insert_delete_list_top.sv */
// Top level of the positional insert/delete list: control, count, cell chain, read tree.
// Depends on pidl_pkg, pidl_cell and pidl_or_tree.
//
// Usage:
//   Slave channel (s_*) takes one operation per transaction: s_tuser carries the
//   op code (insert, delete, read), s_tdata the zero-based position and the value.
//   Master channel (m_*) returns exactly one result per operation: m_tuser holds
//   the status (ok, position out of range, list full, list empty), m_tdata the
//   element count after the operation and the read value (zero unless a read
//   succeeded). A rejected operation changes nothing.
//   Insert and delete are applied to the whole cell chain in the accept cycle:
//   cells from the position up copy a neighbor or load the value; no entry moves twice.
//   A result passes the per-cell read mask register, LEV stages of the 8:1 OR
//   tree (LEV = ceil(log8(DEPTH)), at least 1) and the output register. One
//   operation is in flight at a time: s_tready returns only once the previous
//   result has been loaded into the output register.
//   The output register lets the next operation be accepted while a result
//   still waits; if the receiver stalls, a finished result holds in the tree
//   and s_tready stays low until the output register is free.
//   Reset clears the count (empty list) and the handshake state; cell contents
//   are not reset and are never read before written.
module positional_insert_delete_list_top #(
  parameter int DEPTH = pidl_pkg::DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [39:0] s_tdata,   // [6:0] position, [38:7] value, [39] zero pad
  input  logic [1:0]  s_tuser,   // [1:0] op
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata,   // [6:0] count, [38:7] read_value, [39] zero pad
  output logic [1:0]  m_tuser    // [1:0] status
);

  localparam int DW   = pidl_pkg::DATA_W;
  localparam int PW   = pidl_pkg::POS_W;
  localparam int CW   = $clog2(DEPTH + 1);
  localparam int CMPW = (CW > PW) ? CW : PW;
  localparam int LEV  = pidl_pkg::tree_levels(DEPTH);
  localparam int LAT  = LEV + 1;  // tick value at which the tree output is valid
  localparam int TW   = $clog2(LAT + 1);

  typedef enum logic {S_IDLE, S_RUN} state_t;

  // input fields
  logic [PW-1:0]             in_pos;
  logic [DW-1:0]             in_value;
  logic [pidl_pkg::OP_W-1:0] in_op;

  assign in_pos   = s_tdata[6:0];
  assign in_value = s_tdata[38:7];
  assign in_op    = s_tuser;

  state_t                    state;
  logic [TW-1:0]             tick;
  logic [CW-1:0]             cnt;
  logic [CW-1:0]             cnt_next;
  logic [PW-1:0]             pos_q;
  logic [pidl_pkg::ST_W-1:0] status_q;
  logic [CW-1:0]             cnt_q;
  logic                      rd_ok_q;

  logic [pidl_pkg::ST_W-1:0] status_c;
  logic                      do_ins;
  logic                      do_del;
  logic                      do_rd;
  logic                      accept;
  logic                      load_out;
  logic [CMPW-1:0]           pos_x;
  logic [CMPW-1:0]           cnt_x;

  logic [DW-1:0]             cell_data [DEPTH];
  logic [DW-1:0]             cell_rd   [DEPTH];
  logic [DW-1:0]             tree_out;

  logic [DW-1:0]             m_rd_value;
  logic [pidl_pkg::ST_W-1:0] m_status;
  logic [31:0]               cnt32;

  assign s_tready = (state == S_IDLE);
  assign accept   = s_tvalid & s_tready;
  assign load_out = (state == S_RUN) && (tick == TW'(LAT)) && (!m_tvalid || m_tready);

  assign pos_x = CMPW'(in_pos);
  assign cnt_x = CMPW'(cnt);

  // status decision; full and empty take priority over the range check
  always_comb begin
    status_c = pidl_pkg::ST_OK;
    do_ins   = 1'b0;
    do_del   = 1'b0;
    do_rd    = 1'b0;
    unique case (in_op)
      pidl_pkg::OP_INSERT: begin
        priority if (cnt == CW'(DEPTH)) begin
          status_c = pidl_pkg::ST_FULL;
        end else if (pos_x > cnt_x) begin
          status_c = pidl_pkg::ST_RANGE;
        end else begin
          do_ins = 1'b1;
        end
      end
      pidl_pkg::OP_DELETE, pidl_pkg::OP_READ: begin
        priority if (cnt == '0) begin
          status_c = pidl_pkg::ST_EMPTY;
        end else if (pos_x >= cnt_x) begin
          status_c = pidl_pkg::ST_RANGE;
        end else if (in_op == pidl_pkg::OP_DELETE) begin
          do_del = 1'b1;
        end else begin
          do_rd = 1'b1;
        end
      end
      default: begin
        status_c = pidl_pkg::ST_OK;  // unused op: no-op
      end
    endcase
  end

  always_comb begin
    cnt_next = cnt;
    if (accept && do_ins) begin
      cnt_next = cnt + CW'(1);
    end else if (accept && do_del) begin
      cnt_next = cnt - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else begin
      cnt <= cnt_next;
    end
  end

  // cell chain: each cell sees its neighbors' current entries
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    pidl_pkg::cell_ctl_t     ctl;
    logic [DW-1:0]           prev_d;
    logic [DW-1:0]           next_d;

    assign ctl.take_prev = accept && do_ins && (pos_x < CMPW'(i));
    assign ctl.load      = accept && do_ins && (pos_x == CMPW'(i));
    assign ctl.take_next = accept && do_del && (pos_x <= CMPW'(i));
    assign ctl.sel       = (CMPW'(pos_q) == CMPW'(i));

    if (i == 0) begin : g_first
      assign prev_d = '0;
    end else begin : g_mid_lo
      assign prev_d = cell_data[i - 1];
    end
    if (i == DEPTH - 1) begin : g_last
      assign next_d = '0;
    end else begin : g_mid_hi
      assign next_d = cell_data[i + 1];
    end

    pidl_cell u_cell (
      .clk       (clk),
      .ctl       (ctl),
      .value     (in_value),
      .prev_data (prev_d),
      .next_data (next_d),
      .data      (cell_data[i]),
      .rd_word   (cell_rd[i])
    );
  end

  pidl_or_tree #(
    .DEPTH (DEPTH)
  ) u_tree (
    .clk  (clk),
    .din  (cell_rd),
    .dout (tree_out)
  );

  // sequencer and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      tick     <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (m_tvalid && m_tready && !load_out) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            state    <= S_RUN;
            tick     <= '0;
            pos_q    <= in_pos;
            status_q <= status_c;
            cnt_q    <= cnt_next;
            rd_ok_q  <= do_rd;
          end
        end
        S_RUN: begin
          if (tick != TW'(LAT)) begin
            tick <= tick + TW'(1);
          end
          if (load_out) begin
            state      <= S_IDLE;
            m_tvalid   <= 1'b1;
            m_status   <= status_q;
            cnt32      <= 32'(cnt_q);
            m_rd_value <= rd_ok_q ? tree_out : '0;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign m_tuser = m_status;
  assign m_tdata = {1'b0, m_rd_value, cnt32[pidl_pkg::CNT_OUT_W-1:0]};

  // the count never exceeds the list depth
  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    cnt <= CW'(DEPTH))
    else $error("element count above depth");

  // a rejected operation leaves the count unchanged
  a_reject_hold: assert property (@(posedge clk) disable iff (rst)
    (accept && status_c != pidl_pkg::ST_OK) |=> (cnt == $past(cnt)))
    else $error("rejected operation changed the count");

  // the list is frozen while an operation is in flight; checked here on the count
  a_run_frozen: assert property (@(posedge clk) disable iff (rst)
    (state == S_RUN) |=> $stable(cnt))
    else $error("count changed during an operation");

endmodule

/* dv/tb.sv */
`timescale 1ns / 1ps
// Self-checking testbench for positional_insert_delete_list_top: directed edge cases,
// a fill/overflow/drain sweep and biased random traffic. A local list model predicts results.
// Depends on pidl_pkg and the RTL of the block only.
module tb;

  localparam int LIST_DEPTH = pidl_pkg::DEPTH_DEF;
  localparam logic [pidl_pkg::OP_W-1:0] OP_NOP = 2'd3;  // unused code, must act as a no-op
  localparam int TAIL_CYCLES = 16;

  // one expected transaction on the master side
  typedef struct {
    logic [pidl_pkg::ST_W-1:0]   status;
    logic [pidl_pkg::POS_W-1:0]  count;
    logic [pidl_pkg::DATA_W-1:0] read_value;
  } list_result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [39:0] s_tdata = '0;   // [6:0] position, [38:7] value, [39] zero pad
  logic [1:0]  s_tuser = '0;   // [1:0] op
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [39:0] m_tdata;        // [6:0] count, [38:7] read_value, [39] zero pad
  logic [1:0]  m_tuser;        // [1:0] status

  positional_insert_delete_list_top dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  // Shadow copy of the list; entries at and above list_len are never read.
  logic [pidl_pkg::DATA_W-1:0] list_vals [LIST_DEPTH];
  int                list_len;
  list_result_t      pending_results[$];

  // idle rates in percent, changed per phase
  int tx_idle_pct;
  int rx_stall_pct;

  int n_errors;
  int n_sent;
  int n_checked;
  int status_seen [4];
  int max_len_seen;

  initial begin
    forever #5 clk = ~clk;
  end

  // Reset is asserted once, at the start.
  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;
  end

  // Watchdog: far beyond the slowest legal run (~2000 transactions, one in flight
  // at a time, receiver stalls).
  initial begin
    #5_000_000;
    $display("positional_insert_delete_list_top: mismatch");
    $finish;
  end

  task automatic report_mismatch(input string what, input logic [31:0] want,
                                 input logic [31:0] got);
    n_errors++;
    $display("ERROR t=%0t %s: expected %h got %h", $realtime, what, want, got);
  endtask

  // Applies one operation to the shadow list and returns the result it gives.
  // Full and empty take priority over the position check.
  function automatic list_result_t apply_list_op(input logic [pidl_pkg::OP_W-1:0] op,
                                                 input logic [pidl_pkg::POS_W-1:0] pos,
                                                 input logic [pidl_pkg::DATA_W-1:0] val);
    list_result_t res;
    res.status     = pidl_pkg::ST_OK;
    res.read_value = '0;
    case (op)
      pidl_pkg::OP_INSERT: begin
        if (list_len >= LIST_DEPTH) begin
          res.status = pidl_pkg::ST_FULL;
        end else if (int'(pos) > list_len) begin
          res.status = pidl_pkg::ST_RANGE;
        end else begin
          for (int i = list_len; i > int'(pos); i--) list_vals[i] = list_vals[i-1];
          list_vals[pos] = val;
          list_len++;
        end
      end
      pidl_pkg::OP_DELETE: begin
        if (list_len == 0) begin
          res.status = pidl_pkg::ST_EMPTY;
        end else if (int'(pos) >= list_len) begin
          res.status = pidl_pkg::ST_RANGE;
        end else begin
          for (int i = int'(pos); i + 1 < list_len; i++) list_vals[i] = list_vals[i+1];
          list_len--;
        end
      end
      pidl_pkg::OP_READ: begin
        if (list_len == 0) begin
          res.status = pidl_pkg::ST_EMPTY;
        end else if (int'(pos) >= list_len) begin
          res.status = pidl_pkg::ST_RANGE;
        end else begin
          res.read_value = list_vals[pos];
        end
      end
      default: ;
    endcase
    res.count = list_len[pidl_pkg::POS_W-1:0];
    if (list_len > max_len_seen) max_len_seen = list_len;
    return res;
  endfunction

  // Sends one operation. Called right after a rising edge; tvalid stays high
  // between back-to-back transactions and only drops on an idle cycle.
  task automatic send_op(input logic [pidl_pkg::OP_W-1:0] op,
                         input logic [pidl_pkg::POS_W-1:0] pos,
                         input logic [pidl_pkg::DATA_W-1:0] val);
    while ($urandom_range(99) < tx_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= op;
    s_tdata  <= {1'b0, val, pos};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    pending_results.push_back(apply_list_op(op, pos, val));
    n_sent++;
  endtask

  // Sender holds off until every outstanding result has been returned.
  task automatic hold_until_drained();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // Receiver: random backpressure, and the result check on every transaction.
  always @(posedge clk) begin
    list_result_t want;
    m_tready <= ($urandom_range(99) >= rx_stall_pct);
    if (!rst && m_tvalid && m_tready) begin
      if (pending_results.size() == 0) begin
        report_mismatch("result with nothing outstanding", '0, m_tdata[31:0]);
      end else begin
        want = pending_results.pop_front();
        n_checked++;
        status_seen[m_tuser]++;
        if (m_tuser !== want.status)
          report_mismatch("status", 32'(want.status), 32'(m_tuser));
        if (m_tdata[6:0] !== want.count)
          report_mismatch("count", 32'(want.count), 32'(m_tdata[6:0]));
        if (m_tdata[38:7] !== want.read_value)
          report_mismatch("read_value", want.read_value, m_tdata[38:7]);
        if (m_tdata[39] !== 1'b0)
          report_mismatch("tdata pad bit", '0, 32'(m_tdata[39]));
      end
    end
  end

  // Empty-list behavior, no-op code, and field extremes on a short list.
  task automatic test_edge_cases();
    send_op(pidl_pkg::OP_READ,   7'd0,   32'h0);           // empty read
    send_op(pidl_pkg::OP_DELETE, 7'd127, 32'hFFFF_FFFF);   // empty delete beats range
    send_op(pidl_pkg::OP_INSERT, 7'd1,   32'h1234_5678);   // insert past end of empty list
    send_op(pidl_pkg::OP_INSERT, 7'd0,   32'h7FFF_FFFF);   // first element
    send_op(pidl_pkg::OP_INSERT, 7'd1,   32'h8000_0000);   // append at count
    send_op(pidl_pkg::OP_INSERT, 7'd0,   32'hFFFF_FFFF);   // insert at head shifts all up
    send_op(pidl_pkg::OP_INSERT, 7'd1,   32'hAAAA_AAAA);   // middle
    send_op(pidl_pkg::OP_INSERT, 7'd2,   32'h5555_5555);
    send_op(pidl_pkg::OP_INSERT, 7'd6,   32'h0);           // count + 1
    send_op(OP_NOP,              7'd127, 32'hFFFF_FFFF);   // unused op
    send_op(OP_NOP,              7'd0,   32'h0);
    for (int i = 0; i < 5; i++) send_op(pidl_pkg::OP_READ, 7'(i), $urandom);
    send_op(pidl_pkg::OP_READ,   7'd5,   32'h0);           // read at count
    send_op(pidl_pkg::OP_READ,   7'd127, 32'h0);
    send_op(pidl_pkg::OP_DELETE, 7'd64,  32'h0);
    send_op(pidl_pkg::OP_DELETE, 7'd2,   32'h0);           // middle delete shifts down
    send_op(pidl_pkg::OP_DELETE, 7'd3,   32'h0);           // last element
    send_op(pidl_pkg::OP_READ,   7'd2,   32'h0);
    send_op(pidl_pkg::OP_DELETE, 7'd0,   32'h0);           // head delete
    hold_until_drained();
  endtask

  // Fill to DEPTH at random positions, hit the full cases, then drain to empty.
  task automatic test_fill_and_empty();
    while (list_len < LIST_DEPTH)
      send_op(pidl_pkg::OP_INSERT, 7'($urandom_range(list_len)), $urandom);
    send_op(pidl_pkg::OP_INSERT, 7'd0,   32'h1);
    send_op(pidl_pkg::OP_INSERT, 7'd64,  32'h2);           // full beats an append position
    send_op(pidl_pkg::OP_INSERT, 7'd127, 32'h3);           // full beats range
    send_op(pidl_pkg::OP_READ,   7'd63,  32'h0);
    send_op(pidl_pkg::OP_READ,   7'd64,  32'h0);
    send_op(pidl_pkg::OP_DELETE, 7'd64,  32'h0);
    send_op(pidl_pkg::OP_DELETE, 7'd63,  32'h0);
    send_op(pidl_pkg::OP_INSERT, 7'd63,  32'h8000_0001);   // refill the top slot
    hold_until_drained();
    while (list_len > 0) begin
      if ($urandom_range(3) == 0)
        send_op(pidl_pkg::OP_READ, 7'($urandom_range(list_len - 1)), 32'h0);
      send_op(pidl_pkg::OP_DELETE, 7'($urandom_range(list_len - 1)), 32'h0);
    end
    send_op(pidl_pkg::OP_DELETE, 7'd0, 32'h0);
    send_op(pidl_pkg::OP_READ,   7'd0, 32'h0);
  endtask

  function automatic logic [pidl_pkg::DATA_W-1:0] pick_value();
    case ($urandom_range(19))
      0:       return 32'h8000_0000;
      1:       return 32'h7FFF_FFFF;
      2:       return 32'hFFFF_FFFF;
      3:       return 32'h0;
      default: return $urandom;
    endcase
  endfunction

  // Position: mostly legal for the op, sometimes past the end or at a boundary.
  function automatic logic [pidl_pkg::POS_W-1:0] pick_position(
      input logic [pidl_pkg::OP_W-1:0] op);
    int r;
    int top;
    r   = $urandom_range(99);
    top = (op == pidl_pkg::OP_INSERT) ? list_len : list_len - 1;
    if (r < 82 && top >= 0) return 7'($urandom_range(top));
    if (r < 94) return 7'($urandom_range(127, top + 1));
    case ($urandom_range(4))
      0:       return 7'd0;
      1:       return 7'(list_len);
      2:       return 7'd63;
      3:       return 7'd64;
      default: return 7'd127;
    endcase
  endfunction

  // Random traffic in trends of 100 transactions (grow, shrink, balanced) so
  // the list sweeps between empty and full with random content.
  task automatic test_random_traffic(input int n_items);
    int trend;
    int insert_pct;
    int r;
    logic [pidl_pkg::OP_W-1:0] op;
    trend = 2;
    for (int i = 0; i < n_items; i++) begin
      if (i % 100 == 0) trend = $urandom_range(2);
      if (i % 150 == 149 && $urandom_range(1) == 0) hold_until_drained();
      insert_pct = (trend == 0) ? 70 : (trend == 1) ? 25 : 45;
      r = $urandom_range(99);
      if (r < 3)
        op = OP_NOP;
      else if (r < 3 + insert_pct)
        op = pidl_pkg::OP_INSERT;
      else if ($urandom_range(2) != 0)
        op = pidl_pkg::OP_DELETE;
      else
        op = pidl_pkg::OP_READ;
      send_op(op, pick_position(op), pick_value());
    end
  endtask

  // Test sequence: each idling profile gets its share of random traffic; the directed
  // edge cases run under the first profile, the fill/drain sweep under the first and last.
  initial begin
    n_errors     = 0;
    n_sent       = 0;
    n_checked    = 0;
    max_len_seen = 0;
    list_len     = 0;
    status_seen  = '{default: 0};
    tx_idle_pct  = 33;
    rx_stall_pct = 57;
    @(posedge clk);
    while (rst) @(posedge clk);

    test_edge_cases();
    test_fill_and_empty();
    test_random_traffic(500);

    tx_idle_pct  = 57;
    rx_stall_pct = 33;
    test_random_traffic(500);

    tx_idle_pct  = 0;
    rx_stall_pct = 0;
    test_fill_and_empty();
    test_random_traffic(500);

    // final drain, then a quiet tail to catch stray results
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Covered %0d transactions (%0d checked), list length up to %0d of %0d.",
             n_sent, n_checked, max_len_seen, LIST_DEPTH);
    $display("Status mix: ok %0d, range %0d, full %0d, empty %0d; %0d errors.",
             status_seen[pidl_pkg::ST_OK], status_seen[pidl_pkg::ST_RANGE],
             status_seen[pidl_pkg::ST_FULL], status_seen[pidl_pkg::ST_EMPTY], n_errors);
    if (n_errors == 0) begin
      $display("positional_insert_delete_list_top: match");
    end else begin
      $display("positional_insert_delete_list_top: mismatch");
    end
    $finish;
  end

endmodule

/* files.f */
hw/rtl/pidl_pkg.sv
hw/rtl/pidl_cell.sv
hw/rtl/pidl_or_tree.sv
hw/rtl/positional_insert_delete_list_top.sv
dv/tb.sv
